[rtl/msgtok_pkg.sv]
package msgtok_pkg;

	localparam int OffsetBitsDefault = 32;

	// token kinds
	localparam logic [3:0] K_NIL   = 4'd0;
	localparam logic [3:0] K_BOOL  = 4'd1;
	localparam logic [3:0] K_UINT  = 4'd2;
	localparam logic [3:0] K_INT   = 4'd3;
	localparam logic [3:0] K_F32   = 4'd4;
	localparam logic [3:0] K_F64   = 4'd5;
	localparam logic [3:0] K_STR   = 4'd6;
	localparam logic [3:0] K_BIN   = 4'd7;
	localparam logic [3:0] K_EXT   = 4'd8;
	localparam logic [3:0] K_ARRAY = 4'd9;
	localparam logic [3:0] K_MAP   = 4'd10;

	// token status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TRUNC   = 2'd2;

	// header code landmarks
	localparam logic [7:0] C_FIXMAP   = 8'h80;
	localparam logic [7:0] C_FIXARRAY = 8'h90;
	localparam logic [7:0] C_FIXSTR   = 8'ha0;
	localparam logic [7:0] C_NIL      = 8'hc0;
	localparam logic [7:0] C_INVALID  = 8'hc1;
	localparam logic [7:0] C_FALSE    = 8'hc2;
	localparam logic [7:0] C_TRUE     = 8'hc3;
	localparam logic [7:0] C_EXT8     = 8'hc7;
	localparam logic [7:0] C_EXT32    = 8'hc9;
	localparam logic [7:0] C_INT8     = 8'hd0;
	localparam logic [7:0] C_INT64    = 8'hd3;
	localparam logic [7:0] C_FIXEXT1  = 8'hd4;
	localparam logic [7:0] C_FIXEXT16 = 8'hd8;
	localparam logic [7:0] C_NEGFIX   = 8'he0;

	localparam logic [7:0] MASK_LEN5 = 8'h1f;
	localparam logic [7:0] MASK_LEN4 = 8'h0f;

	function automatic logic [3:0] kind_of(input logic [7:0] c);
		logic [3:0] k;
		k = K_NIL;
		if (c < C_FIXMAP) begin
			k = K_UINT;
		end else if (c >= C_NEGFIX) begin
			k = K_INT;
		end else if (c < C_FIXARRAY) begin
			k = K_MAP;
		end else if (c < C_FIXSTR) begin
			k = K_ARRAY;
		end else if (c < C_NIL) begin
			k = K_STR;
		end else begin
			unique case (c)
				8'hc2, 8'hc3:                      k = K_BOOL;
				8'hc4, 8'hc5, 8'hc6:               k = K_BIN;
				8'hc7, 8'hc8, 8'hc9:               k = K_EXT;
				8'hca:                             k = K_F32;
				8'hcb:                             k = K_F64;
				8'hcc, 8'hcd, 8'hce, 8'hcf:        k = K_UINT;
				8'hd0, 8'hd1, 8'hd2, 8'hd3:        k = K_INT;
				8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'hd8: k = K_EXT;
				8'hd9, 8'hda, 8'hdb:               k = K_STR;
				8'hdc, 8'hdd:                      k = K_ARRAY;
				8'hde, 8'hdf:                      k = K_MAP;
				default:                           k = K_NIL;
			endcase
		end
		return k;
	endfunction

	// bytes after the code byte, ext type byte not counted
	function automatic logic [3:0] field_len(input logic [7:0] c);
		logic [3:0] n;
		unique case (c)
			8'hc4, 8'hc7, 8'hcc, 8'hd0, 8'hd9:                      n = 4'd1;
			8'hc5, 8'hc8, 8'hcd, 8'hd1, 8'hda, 8'hdc, 8'hde:        n = 4'd2;
			8'hc6, 8'hc9, 8'hca, 8'hce, 8'hd2, 8'hdb, 8'hdd, 8'hdf: n = 4'd4;
			8'hcb, 8'hcf, 8'hd3:                                    n = 4'd8;
			default:                                                n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

[rtl/messagepack_element_tokenizer_core.sv]
// MessagePack tokenizer: one message byte per input beat, tlast on the final byte of a
// message. One token comes out for each element header once its last header byte has
// arrived; blob payload bytes give no token, collection elements follow as their own
// tokens. Code 0xc1 gives an invalid token and the rest of the message is dropped; a
// header or blob payload cut short by tlast gives a truncated token. Each byte is
// registered, decoded against the parse state by one level of logic and the token is
// written into the output register, so a byte is taken each cycle unless a byte already
// waits in the input register behind a full output register that is not being drained.
// The input register and the output register lie between a byte and its token.
module messagepack_element_tokenizer_core #(
	parameter int OFFSET_BITS = msgtok_pkg::OffsetBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
	input  logic         s_axis_tlast,  // last_byte
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [63:0] value, [71:64] ext_type, [103:72] header_offset, [105:104] status, zero fill
	output logic [111:0] m_axis_tdata,
	output logic [3:0]   m_axis_tuser   // [3:0] kind
);
	import msgtok_pkg::*;

	typedef enum logic [2:0] {PH_HEAD, PH_FIELD, PH_EXTT, PH_PAY, PH_ERR} phase_t;

	phase_t                 phase_q, ph_n;
	logic [7:0]             hc_q, hc_n;
	logic [3:0]             fl_q, fl_n;
	logic [63:0]            acc_q, acc_n;
	logic [31:0]            pl_q, pl_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [OFFSET_BITS-1:0] tok_q, tok_n;
	logic [7:0]             ext_q, ext_n;

	logic       valid_s1, last_s1;
	logic [7:0] byte_s1;

	logic        out_valid_q;
	logic [3:0]  kind_q;
	logic [63:0] value_q;
	logic [7:0]  ext_type_q;
	logic [31:0] hoff_q;
	logic [1:0]  status_q;

	logic        adv, take;
	logic        emit, do_complete;
	logic [3:0]  o_kind, ck;
	logic [63:0] o_val, cv;
	logic [7:0]  o_ext;
	logic [1:0]  o_stat;

	assign adv = !out_valid_q || m_axis_tready;
	assign take = valid_s1 && adv;
	assign s_axis_tready = !valid_s1 || adv;

	always_comb begin
		ph_n = phase_q;
		hc_n = hc_q;
		fl_n = fl_q;
		acc_n = acc_q;
		pl_n = pl_q;
		pos_n = pos_q + 1'b1;
		tok_n = tok_q;
		ext_n = ext_q;
		emit = 1'b0;
		do_complete = 1'b0;
		o_kind = K_NIL;
		o_val = '0;
		o_ext = '0;
		o_stat = ST_OK;
		ck = K_NIL;
		cv = '0;

		unique case (phase_q)
			PH_HEAD: begin
				tok_n = pos_q;
				hc_n = byte_s1;
				acc_n = '0;
				ext_n = '0;
				if (byte_s1 == C_INVALID) begin
					emit = 1'b1;
					o_stat = ST_INVALID;
					ph_n = PH_ERR;
				end else if (byte_s1 >= C_FIXEXT1 && byte_s1 <= C_FIXEXT16) begin
					acc_n = 64'd1 << (byte_s1 - C_FIXEXT1);
					ph_n = PH_EXTT;
				end else if (field_len(byte_s1) != 4'd0) begin
					fl_n = field_len(byte_s1);
					ph_n = PH_FIELD;
				end else begin
					do_complete = 1'b1;
				end
			end
			PH_FIELD: begin
				acc_n = {acc_q[55:0], byte_s1};
				fl_n = fl_q - 1'b1;
				if (fl_n == 4'd0) begin
					if (hc_q >= C_EXT8 && hc_q <= C_EXT32) begin
						ph_n = PH_EXTT;
					end else begin
						do_complete = 1'b1;
					end
				end
			end
			PH_EXTT: begin
				ext_n = byte_s1;
				do_complete = 1'b1;
			end
			PH_PAY: begin
				if (pl_q != '0) begin
					pl_n = pl_q - 1'b1;
				end
				if (pl_n == '0) begin
					ph_n = PH_HEAD;
				end
			end
			default: begin
			end
		endcase

		if (do_complete) begin
			ck = kind_of(hc_n);
			priority if (hc_n < C_FIXMAP) begin
				cv = {56'd0, hc_n};
			end else if (hc_n >= C_NEGFIX) begin
				cv = {{56{1'b1}}, hc_n};
			end else if (hc_n < C_FIXSTR) begin
				cv = {56'd0, hc_n & MASK_LEN4};
			end else if (hc_n < C_NIL) begin
				cv = {56'd0, hc_n & MASK_LEN5};
			end else if (hc_n == C_NIL) begin
				cv = '0;
			end else if (hc_n == C_FALSE || hc_n == C_TRUE) begin
				cv = {63'd0, hc_n[0]};
			end else if (hc_n >= C_INT8 && hc_n <= C_INT64) begin
				// sign extend from 8 << (code - int8) bits
				unique case (hc_n[1:0])
					2'd0:    cv = {{56{acc_n[7]}}, acc_n[7:0]};
					2'd1:    cv = {{48{acc_n[15]}}, acc_n[15:0]};
					2'd2:    cv = {{32{acc_n[31]}}, acc_n[31:0]};
					default: cv = acc_n;
				endcase
			end else begin
				cv = acc_n;
			end
			emit = 1'b1;
			o_kind = ck;
			o_val = cv;
			o_ext = (ck == K_EXT) ? ext_n : 8'd0;
			o_stat = ST_OK;
			// blob lengths never exceed 32 bits
			if ((ck == K_STR || ck == K_BIN || ck == K_EXT) && cv != '0) begin
				acc_n = cv;
				pl_n = cv[31:0];
				ph_n = PH_PAY;
			end else begin
				ph_n = PH_HEAD;
			end
		end

		if (last_s1) begin
			if (ph_n == PH_FIELD || ph_n == PH_EXTT) begin
				emit = 1'b1;
				o_kind = kind_of(hc_n);
				o_val = '0;
				o_ext = '0;
				o_stat = ST_TRUNC;
			end else if (ph_n == PH_PAY) begin
				if (!emit) begin
					o_kind = kind_of(hc_n);
					o_val = acc_n;
					o_ext = (kind_of(hc_n) == K_EXT) ? ext_n : 8'd0;
				end
				emit = 1'b1;
				o_stat = ST_TRUNC;
			end
			ph_n = PH_HEAD;
			hc_n = '0;
			fl_n = '0;
			acc_n = '0;
			pl_n = '0;
			pos_n = '0;
			ext_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q <= PH_HEAD;
			hc_q <= '0;
			fl_q <= '0;
			acc_q <= '0;
			pl_q <= '0;
			pos_q <= '0;
			tok_q <= '0;
			ext_q <= '0;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= valid_s1 && emit;
			end
			if (take) begin
				phase_q <= ph_n;
				hc_q <= hc_n;
				fl_q <= fl_n;
				acc_q <= acc_n;
				pl_q <= pl_n;
				pos_q <= pos_n;
				// token offset returns to zero with the rest of the state at message end
				tok_q <= last_s1 ? '0 : tok_n;
				ext_q <= ext_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (take && emit) begin
			kind_q <= o_kind;
			value_q <= o_val;
			ext_type_q <= o_ext;
			hoff_q <= 32'(tok_n);
			status_q <= o_stat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser = kind_q;
	assign m_axis_tdata = {6'd0, status_q, hoff_q, ext_type_q, value_q};

`ifndef NO_ASSERTIONS
	a_pay_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAY |-> pl_q != '0)
		else $error("payload phase with nothing left");

	a_field_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FIELD |-> (fl_q != 4'd0 && fl_q <= 4'd8))
		else $error("header field count out of range");

	a_invalid_nil: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == ST_INVALID) |-> (kind_q == K_NIL && value_q == '0))
		else $error("invalid token carries a kind or value");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_s1) |=> (phase_q == PH_HEAD && pos_q == '0))
		else $error("parse state not restarted after message end");

	a_ext_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != K_EXT) |-> ext_type_q == 8'd0)
		else $error("ext type on a non-ext token");
`endif

endmodule

[bench/messagepack_element_tokenizer_core_tb.sv]
`timescale 1ns / 1ps

module messagepack_element_tokenizer_core_tb;
	import msgtok_pkg::*;

	localparam int RANDOM_BYTES = 1150;
	localparam int QUIET_LIMIT  = 2000;
	localparam int N_DIRECTED   = 26;

	// header codes not named in the package
	localparam logic [7:0] C_BIN8    = 8'hc4;
	localparam logic [7:0] C_F32     = 8'hca;
	localparam logic [7:0] C_F64     = 8'hcb;
	localparam logic [7:0] C_UINT8   = 8'hcc;
	localparam logic [7:0] C_UINT64  = 8'hcf;
	localparam logic [7:0] C_INT16   = 8'hd1;
	localparam logic [7:0] C_INT32   = 8'hd2;
	localparam logic [7:0] C_STR8    = 8'hd9;
	localparam logic [7:0] C_ARRAY16 = 8'hdc;
	localparam logic [7:0] C_MAP32   = 8'hdf;

	typedef enum logic [2:0] {
		AT_HEADER, IN_FIELD, AT_EXT_TYPE, IN_PAYLOAD, DROPPING
	} parse_phase_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [63:0] value;
		logic [7:0]  ext_type;
		logic [31:0] offset;
		logic [1:0]  status;
	} token_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        last;
		logic        fixed;
		logic [3:0]  kind;
		logic [63:0] value;
		logic [7:0]  ext_type;
		logic [31:0] offset;
		logic [1:0]  status;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;
	logic s_axis_tlast;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [111:0] m_axis_tdata;
	logic [3:0] m_axis_tuser;

	messagepack_element_tokenizer_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	token_t expected_tokens [$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	int bytes_sent = 0;

	// tokenizer state mirror
	parse_phase_t p_phase = AT_HEADER;
	logic [7:0]  p_code = '0;
	logic [3:0]  p_field_left = '0;
	logic [63:0] p_acc = '0;
	logic [32:0] p_payload_left = '0;
	logic [31:0] p_pos = '0;
	logic [31:0] p_token_pos = '0;
	logic [7:0]  p_ext = '0;

	function automatic logic [3:0] kind_for_code(input logic [7:0] c);
		if (c < C_FIXMAP) return K_UINT;
		if (c >= C_NEGFIX) return K_INT;
		if (c < C_FIXARRAY) return K_MAP;
		if (c < C_FIXSTR) return K_ARRAY;
		if (c < C_NIL) return K_STR;
		if (c == C_FALSE || c == C_TRUE) return K_BOOL;
		if (c >= C_BIN8 && c < C_EXT8) return K_BIN;
		if (c >= C_EXT8 && c <= C_EXT32) return K_EXT;
		if (c == C_F32) return K_F32;
		if (c == C_F64) return K_F64;
		if (c >= C_UINT8 && c <= C_UINT64) return K_UINT;
		if (c >= C_INT8 && c <= C_INT64) return K_INT;
		if (c >= C_FIXEXT1 && c <= C_FIXEXT16) return K_EXT;
		if (c >= C_STR8 && c < C_ARRAY16) return K_STR;
		if (c >= C_ARRAY16 && c < C_ARRAY16 + 8'd2) return K_ARRAY;
		if (c >= C_ARRAY16 + 8'd2 && c <= C_MAP32) return K_MAP;
		return K_NIL;
	endfunction

	// length or number bytes that follow the code byte
	function automatic logic [3:0] field_bytes_for(input logic [7:0] c);
		logic [1:0] sz;
		if (c >= C_BIN8 && c < C_EXT8) sz = 2'(c - C_BIN8);
		else if (c >= C_EXT8 && c <= C_EXT32) sz = 2'(c - C_EXT8);
		else if (c == C_F32) sz = 2'd2;
		else if (c == C_F64) sz = 2'd3;
		else if (c >= C_UINT8 && c <= C_INT64) sz = c[1:0];
		else if (c >= C_STR8 && c < C_ARRAY16) sz = 2'(c - C_STR8);
		else if (c >= C_ARRAY16 && c <= C_MAP32) sz = c[0] ? 2'd2 : 2'd1;
		else return 4'd0;
		return 4'd1 << sz;
	endfunction

	function automatic token_t header_done();
		token_t t;
		logic [63:0] v;
		logic [3:0] k;
		k = kind_for_code(p_code);
		if (p_code < C_FIXMAP) v = {56'd0, p_code};
		else if (p_code >= C_NEGFIX) v = {{56{1'b1}}, p_code};
		else if (p_code < C_FIXSTR) v = {60'd0, p_code[3:0]};
		else if (p_code < C_NIL) v = {59'd0, p_code[4:0]};
		else if (p_code == C_FALSE || p_code == C_TRUE) v = {63'd0, p_code[0]};
		else if (p_code == C_NIL) v = '0;
		else if (p_code == C_INT8) v = {{56{p_acc[7]}}, p_acc[7:0]};
		else if (p_code == C_INT16) v = {{48{p_acc[15]}}, p_acc[15:0]};
		else if (p_code == C_INT32) v = {{32{p_acc[31]}}, p_acc[31:0]};
		else v = p_acc;
		t.kind = k;
		t.value = v;
		t.ext_type = (k == K_EXT) ? p_ext : 8'd0;
		t.offset = p_token_pos;
		t.status = ST_OK;
		if ((k == K_STR || k == K_BIN || k == K_EXT) && v != 0) begin
			p_acc = v;
			p_payload_left = v[32:0];
			p_phase = IN_PAYLOAD;
		end else begin
			p_phase = AT_HEADER;
		end
		return t;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] b, input logic l,
	                                      output bit got, output token_t t);
		got = 0;
		t = '0;
		case (p_phase)
			AT_HEADER: begin
				p_token_pos = p_pos;
				p_code = b;
				p_acc = '0;
				p_ext = '0;
				if (b == C_INVALID) begin
					t.kind = K_NIL;
					t.offset = p_token_pos;
					t.status = ST_INVALID;
					got = 1;
					p_phase = DROPPING;
				end else if (b >= C_FIXEXT1 && b <= C_FIXEXT16) begin
					p_acc = 64'd1 << (b - C_FIXEXT1);
					p_phase = AT_EXT_TYPE;
				end else if (field_bytes_for(b) != 0) begin
					p_field_left = field_bytes_for(b);
					p_phase = IN_FIELD;
				end else begin
					t = header_done();
					got = 1;
				end
			end
			IN_FIELD: begin
				p_acc = {p_acc[55:0], b};
				p_field_left = p_field_left - 4'd1;
				if (p_field_left == 0) begin
					if (p_code >= C_EXT8 && p_code <= C_EXT32) begin
						p_phase = AT_EXT_TYPE;
					end else begin
						t = header_done();
						got = 1;
					end
				end
			end
			AT_EXT_TYPE: begin
				p_ext = b;
				t = header_done();
				got = 1;
			end
			IN_PAYLOAD: begin
				if (p_payload_left != 0) p_payload_left = p_payload_left - 33'd1;
				if (p_payload_left == 0) p_phase = AT_HEADER;
			end
			default: ;
		endcase
		if (l) begin
			if (p_phase == IN_FIELD || p_phase == AT_EXT_TYPE) begin
				t = '0;
				t.kind = kind_for_code(p_code);
				t.offset = p_token_pos;
				t.status = ST_TRUNC;
				got = 1;
			end else if (p_phase == IN_PAYLOAD) begin
				// blob cut short, or its header completed on the final byte
				if (!got) begin
					t.kind = kind_for_code(p_code);
					t.value = p_acc;
					t.ext_type = (t.kind == K_EXT) ? p_ext : 8'd0;
					t.offset = p_token_pos;
				end
				t.status = ST_TRUNC;
				got = 1;
			end
			p_phase = AT_HEADER;
			p_code = '0;
			p_field_left = '0;
			p_acc = '0;
			p_payload_left = '0;
			p_pos = '0;
			p_token_pos = '0;
			p_ext = '0;
		end else begin
			p_pos = p_pos + 32'd1;
		end
	endfunction

	// one byte beat, with random gaps before it
	task automatic send_byte(input logic [7:0] b, input logic l, input bit fixed,
	                         input token_t fixed_tok);
		bit got;
		token_t t;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		tokenize_byte(b, l, got, t);
		if (fixed) expected_tokens.push_back(fixed_tok);
		else if (got) expected_tokens.push_back(t);
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// token checker and watchdog
	always @(posedge clk) begin
		token_t seen;
		token_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				seen.kind = m_axis_tuser;
				seen.value = m_axis_tdata[63:0];
				seen.ext_type = m_axis_tdata[71:64];
				seen.offset = m_axis_tdata[103:72];
				seen.status = m_axis_tdata[105:104];
				if (expected_tokens.size() == 0) begin
					if (mismatches < 10)
						$display("%0t unexpected token kind=%0d value=%h ext=%h off=%0d st=%0d",
							$realtime, seen.kind, seen.value, seen.ext_type, seen.offset,
							seen.status);
					mismatches++;
				end else begin
					want = expected_tokens.pop_front();
					if (seen != want) begin
						if (mismatches < 10) begin
							$display("%0t token mismatch", $realtime);
							$display("  exp kind=%0d value=%h ext=%h off=%0d st=%0d",
								want.kind, want.value, want.ext_type, want.offset, want.status);
							$display("  got kind=%0d value=%h ext=%h off=%0d st=%0d",
								seen.kind, seen.value, seen.ext_type, seen.offset, seen.status);
						end
						mismatches++;
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("TEST FAILED");
					$finish;
				end
			end
		end
	end

	// message builder
	logic [7:0] msg_bytes [$];
	bit msg_cut;

	function automatic void push_random(input int n);
		for (int i = 0; i < n; i++) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void push_be(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) msg_bytes.push_back(v[8*i +: 8]);
	endfunction

	// a declared length over 40 ends the message inside its payload
	function automatic void add_blob(input logic [7:0] code, input int w, input bit with_type);
		logic [31:0] len;
		if ($urandom_range(0, 9) == 0)
			len = (w == 1) ? 32'($urandom_range(0, 255)) :
			      (w == 2) ? 32'($urandom_range(0, 65535)) : 32'($urandom);
		else
			len = 32'($urandom_range(0, 20));
		msg_bytes.push_back(code);
		push_be(len, w);
		if (with_type) push_random(1);
		if (len > 40) begin
			push_random($urandom_range(0, 6));
			msg_cut = 1;
		end else begin
			push_random(int'(len));
		end
	endfunction

	function automatic void add_element(input int depth);
		int sel;
		int r;
		int n;
		logic [7:0] code;
		if (msg_cut) return;
		sel = $urandom_range(0, 13);
		r = $urandom_range(0, 3);
		n = 0;
		case (sel)
			0: msg_bytes.push_back(8'($urandom_range(0, 127)));
			1: msg_bytes.push_back(8'($urandom_range(224, 255)));
			2: msg_bytes.push_back(r == 0 ? C_NIL : r == 1 ? C_FALSE : C_TRUE);
			3: begin
				msg_bytes.push_back(C_UINT8 + 8'(r));
				push_random(1 << r);
			end
			4: begin
				msg_bytes.push_back(C_INT8 + 8'(r));
				push_random(1 << r);
			end
			5: begin
				msg_bytes.push_back(r[0] ? C_F64 : C_F32);
				push_random(r[0] ? 8 : 4);
			end
			6: begin
				n = $urandom_range(0, 31);
				msg_bytes.push_back(C_FIXSTR | 8'(n));
				push_random(n);
				n = 0;
			end
			7: begin
				r = $urandom_range(0, 2);
				add_blob(C_STR8 + 8'(r), 1 << r, 0);
			end
			8: begin
				r = $urandom_range(0, 2);
				add_blob(C_BIN8 + 8'(r), 1 << r, 0);
			end
			9: begin
				r = $urandom_range(0, 2);
				add_blob(C_EXT8 + 8'(r), 1 << r, 1);
			end
			10: begin
				r = $urandom_range(0, 4);
				msg_bytes.push_back(C_FIXEXT1 + 8'(r));
				push_random(1 + (1 << r));
			end
			11: begin
				n = $urandom_range(0, 15);
				msg_bytes.push_back(C_FIXARRAY | 8'(n));
			end
			12: begin
				n = $urandom_range(0, 15);
				msg_bytes.push_back(C_FIXMAP | 8'(n));
				n = 2 * n;
			end
			default: begin
				code = C_ARRAY16 + 8'(r);
				msg_bytes.push_back(code);
				push_random(code[0] ? 4 : 2);
				n = $urandom_range(0, 3);
				if (code >= C_ARRAY16 + 8'd2) n = 2 * n;
			end
		endcase
		// element counts are not tracked by the block, so keep nesting shallow
		if (depth < 2) begin
			if (n > 6) n = 6;
			for (int i = 0; i < n; i++) add_element(depth + 1);
		end
	endfunction

	stim_row_t directed_rows [N_DIRECTED];

	initial begin
		token_t tok;
		int r;
		int seg;
		int cut;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		directed_rows = '{
			'{8'h00, 1'b1, 1'b1, K_UINT, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'hff, 1'b0, 1'b1, K_INT, {64{1'b1}}, 8'h00, 32'd0, ST_OK},
			'{C_NIL, 1'b0, 1'b1, K_NIL, 64'd0, 8'h00, 32'd1, ST_OK},
			'{C_TRUE, 1'b0, 1'b1, K_BOOL, 64'd1, 8'h00, 32'd2, ST_OK},
			'{8'h8f, 1'b0, 1'b1, K_MAP, 64'd15, 8'h00, 32'd3, ST_OK},
			'{C_INVALID, 1'b0, 1'b1, K_NIL, 64'd0, 8'h00, 32'd4, ST_INVALID},
			'{8'h05, 1'b1, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{C_INT8, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h80, 1'b0, 1'b1, K_INT, 64'hffff_ffff_ffff_ff80, 8'h00, 32'd0, ST_OK},
			'{C_UINT8, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'hff, 1'b0, 1'b1, K_UINT, 64'd255, 8'h00, 32'd2, ST_OK},
			'{C_F32, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h7f, 1'b1, 1'b1, K_F32, 64'd0, 8'h00, 32'd4, ST_TRUNC},
			'{C_EXT8, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h02, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h80, 1'b0, 1'b1, K_EXT, 64'd2, 8'h80, 32'd0, ST_OK},
			'{8'haa, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'hbb, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{C_FIXEXT1, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h7f, 1'b0, 1'b1, K_EXT, 64'd1, 8'h7f, 32'd5, ST_OK},
			'{8'h11, 1'b1, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{C_STR8, 1'b0, 1'b0, K_NIL, 64'd0, 8'h00, 32'd0, ST_OK},
			'{8'h05, 1'b1, 1'b1, K_STR, 64'd5, 8'h00, 32'd0, ST_TRUNC},
			'{8'ha3, 1'b0, 1'b1, K_STR, 64'd3, 8'h00, 32'd0, ST_OK},
			'{8'h41, 1'b1, 1'b1, K_STR, 64'd3, 8'h00, 32'd0, ST_TRUNC},
			'{C_FIXARRAY, 1'b1, 1'b1, K_ARRAY, 64'd0, 8'h00, 32'd0, ST_OK}
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			tok.kind = directed_rows[i].kind;
			tok.value = directed_rows[i].value;
			tok.ext_type = directed_rows[i].ext_type;
			tok.offset = directed_rows[i].offset;
			tok.status = directed_rows[i].status;
			send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].fixed, tok);
		end

		while (bytes_sent < RANDOM_BYTES) begin
			// idle and stall pattern steps through four stretches of the run
			seg = bytes_sent * 4 / RANDOM_BYTES;
			idle_pct = (seg == 1) ? 62 : (seg == 3) ? 7 : 0;
			stall_pct = (seg == 2) ? 62 : (seg == 3) ? 7 : 0;
			msg_bytes.delete();
			msg_cut = 0;
			r = $urandom_range(0, 99);
			if (r < 8) begin
				push_random($urandom_range(1, 10));
			end else begin
				repeat ($urandom_range(1, 6)) add_element(0);
				if (r < 14) begin
					msg_bytes.insert($urandom_range(0, msg_bytes.size() - 1), C_INVALID);
				end else if (r < 30) begin
					cut = $urandom_range(1, msg_bytes.size());
					msg_bytes = msg_bytes[0:cut-1];
				end
			end
			for (int i = 0; i < msg_bytes.size(); i++) begin
				send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 0, '0);
				bytes_sent++;
			end
		end

		s_axis_tvalid <= 1'b0;
		stall_pct = 0;
		while (expected_tokens.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_tokens.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[files.f]
rtl/msgtok_pkg.sv
rtl/messagepack_element_tokenizer_core.sv
bench/messagepack_element_tokenizer_core_tb.sv
